>>> rtl/core/skv_pkg.sv
// Package for the key and value sorter: sizes, entry type and cell control.
// Used by skv_cell, sort_key_value_pairs and the testbench; depends on nothing else.
package skv_pkg;

    localparam int DEPTH   = 32;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

endpackage

>>> rtl/core/skv_cell.sv
// One cell of the insertion chain: holds one key and value pair in sorted place.
// Depends on skv_pkg.
module skv_cell (
    input  logic               i_clk,
    input  skv_pkg::t_cell_ctl i_ctl,
    input  skv_pkg::t_idx      i_idx,
    input  skv_pkg::t_cnt      i_fill,
    input  skv_pkg::t_entry    i_new,
    input  logic               i_left_greater,
    input  skv_pkg::t_entry    i_left,
    input  skv_pkg::t_entry    i_right,
    output logic               o_greater,
    output skv_pkg::t_entry    o_entry
);
    import skv_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_empty;

    // An empty cell counts as holding a key above every other, so that a new
    // pair lands behind all equal keys and before the first empty cell.
    assign w_empty   = CNT_W'(i_idx) >= i_fill;
    assign o_greater = w_empty || (r_entry.key > i_new.key);
    assign o_entry   = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.drain) begin
            n_entry = i_right;
        end else if (i_ctl.insert && o_greater) begin
            n_entry = i_left_greater ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> rtl/core/sort_key_value_pairs.sv
// Top level of the stable key and value sorter: fill control and the cell chain.
// Depends on skv_pkg and skv_cell.
//
// Usage: a pair is taken on a beat where i_start is high and o_busy is low.
// Each taken pair is placed at once in its sorted position in a chain of
// DEPTH cells, so input runs at one pair per cycle while o_busy is low.
// Every cell compares its key with the new key in the same cycle and the
// greater ones step right. The pair with i_batch_end high closes the batch.
// From the next cycle o_busy is high and the chain shifts left once per cycle,
// presenting one result per cycle on the result ports with o_result_valid
// high for that single cycle, smallest key first; equal keys leave in
// arrival order. The first result appears in the cycle after the closing beat.
// Pairs arriving while DEPTH pairs are stored are discarded and every result
// of that batch carries o_overflow. o_final_result marks the last result.
// The receiver cannot stall: results are dropped if not taken.
// Reset clears the fill count, the overflow flag and the drain state.
module sort_key_value_pairs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [skv_pkg::KEY_W-1:0] i_sort_key,
    input  logic [skv_pkg::VAL_W-1:0] i_payload,
    input  logic                     i_batch_end,
    output logic                     o_result_valid,
    output logic [skv_pkg::KEY_W-1:0] o_sorted_key,
    output logic [skv_pkg::VAL_W-1:0] o_sorted_payload,
    output logic                     o_final_result,
    output logic                     o_overflow
);
    import skv_pkg::*;

    t_cnt      r_fill;
    logic      r_dropped;
    logic      r_draining;
    logic      w_accept;
    logic      w_full;
    t_cell_ctl w_ctl;
    t_entry    w_new;

    t_entry    w_entry   [DEPTH];
    logic      w_greater [DEPTH];
    t_entry    w_left    [DEPTH];
    logic      w_left_gt [DEPTH];
    t_entry    w_right   [DEPTH];

    assign w_accept     = i_start && !r_draining;
    assign w_full       = r_fill == CNT_W'(DEPTH);
    assign w_ctl.insert = w_accept && !w_full;
    assign w_ctl.drain  = r_draining;
    assign w_new.key     = i_sort_key;
    assign w_new.payload = i_payload;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g]    = w_new;
                assign w_left_gt[g] = 1'b0;
            end else begin : g_mid
                assign w_left[g]    = w_entry[g-1];
                assign w_left_gt[g] = w_greater[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right[g] = w_new;
            end else begin : g_inner
                assign w_right[g] = w_entry[g+1];
            end

            skv_cell u_cell (
                .i_clk          (i_clk),
                .i_ctl          (w_ctl),
                .i_idx          (IDX_W'(g)),
                .i_fill         (r_fill),
                .i_new          (w_new),
                .i_left_greater (w_left_gt[g]),
                .i_left         (w_left[g]),
                .i_right        (w_right[g]),
                .o_greater      (w_greater[g]),
                .o_entry        (w_entry[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_dropped  <= 1'b0;
            r_draining <= 1'b0;
        end else if (r_draining) begin
            r_fill <= r_fill - CNT_W'(1);
            if (r_fill == CNT_W'(1)) begin
                r_draining <= 1'b0;
                r_dropped  <= 1'b0;
            end
        end else if (w_accept) begin
            if (w_full) begin
                r_dropped <= 1'b1;
            end else begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (i_batch_end) begin
                r_draining <= 1'b1;
            end
        end
    end

    assign o_busy           = r_draining;
    assign o_result_valid   = r_draining;
    assign o_sorted_key     = w_entry[0].key;
    assign o_sorted_payload = w_entry[0].payload;
    assign o_final_result   = r_draining && (r_fill == CNT_W'(1));
    assign o_overflow       = r_dropped;

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> r_fill != '0)
        else $error("drain running with an empty chain");

    a_close_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_batch_end) |=> r_draining)
        else $error("closing beat did not start the drain");

    a_final_ends_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_result |=> (!r_draining && !r_dropped && r_fill == '0))
        else $error("batch state not cleared after the final result");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && !r_draining) |=> (r_fill == CNT_W'(DEPTH) && r_dropped))
        else $error("discarded beat changed the fill count");

endmodule

>>> verif/tb.sv
// Self-checking testbench for sort_key_value_pairs, the stable key and value sorter.
// Drives directed and random batches, predicts every sorted beat and checks each one.
// Depends on skv_pkg and the sort_key_value_pairs RTL.
module tb;

    import skv_pkg::*;

    localparam int RANDOM_PAIRS = 160;
    localparam int IDLE_LIMIT   = 4000;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] payload;
        logic             last;
        logic             lost;
    } t_sorted_beat;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] payload;
        bit               closing;
        bit               typed;
        logic [KEY_W-1:0] exp_key;
        logic [VAL_W-1:0] exp_payload;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    logic [KEY_W-1:0] i_sort_key;
    logic [VAL_W-1:0] i_payload;
    logic             i_batch_end;
    logic             o_result_valid;
    logic [KEY_W-1:0] o_sorted_key;
    logic [VAL_W-1:0] o_sorted_payload;
    logic             o_final_result;
    logic             o_overflow;

    t_entry       open_batch[$];
    bit           batch_lost;
    t_sorted_beat pending_sorted[$];
    int           mismatches;
    int           idle_cycles;

    // Typed rows are single-pair batches sent while the store is empty.
    t_stim_row directed_rows[20] = '{
        '{32'h0000_0000, 32'h0000_0000, 1, 1, 32'h0000_0000, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 1, 32'hA5A5_A5A5, 32'h5A5A_5A5A},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0011, 0, 0, 32'h0, 32'h0},
        '{32'h0000_0000, 32'h0000_0012, 0, 0, 32'h0, 32'h0},
        '{32'h0000_0007, 32'h0000_0013, 0, 0, 32'h0, 32'h0},
        '{32'h0000_0007, 32'h0000_0014, 0, 0, 32'h0, 32'h0},
        '{32'h0000_0001, 32'h0000_0015, 1, 0, 32'h0, 32'h0},
        '{32'h0000_0001, 32'h0000_0021, 0, 0, 32'h0, 32'h0},
        '{32'h0000_0002, 32'h0000_0022, 0, 0, 32'h0, 32'h0},
        '{32'h0000_0003, 32'h0000_0023, 1, 0, 32'h0, 32'h0},
        '{32'h0000_0009, 32'h0000_0031, 0, 0, 32'h0, 32'h0},
        '{32'h0000_0005, 32'h0000_0032, 0, 0, 32'h0, 32'h0},
        '{32'h0000_0002, 32'h0000_0033, 1, 0, 32'h0, 32'h0},
        '{32'h8000_0000, 32'h0000_0041, 0, 0, 32'h0, 32'h0},
        '{32'h8000_0000, 32'h0000_0042, 0, 0, 32'h0, 32'h0},
        '{32'h8000_0000, 32'h0000_0043, 1, 0, 32'h0, 32'h0},
        '{32'h8000_0000, 32'h0000_0051, 0, 0, 32'h0, 32'h0},
        '{32'h7FFF_FFFF, 32'h0000_0052, 1, 0, 32'h0, 32'h0}
    };

    sort_key_value_pairs dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_sort_key       (i_sort_key),
        .i_payload        (i_payload),
        .i_batch_end      (i_batch_end),
        .o_result_valid   (o_result_valid),
        .o_sorted_key     (o_sorted_key),
        .o_sorted_payload (o_sorted_payload),
        .o_final_result   (o_final_result),
        .o_overflow       (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stores a taken pair and, on the closing pair, queues the stably sorted batch.
    task automatic store_pair(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] payload,
                              input bit closing);
        t_entry       moving;
        t_entry       fresh;
        t_sorted_beat beat;
        int           j;
        if (open_batch.size() < DEPTH) begin
            fresh.key     = key;
            fresh.payload = payload;
            open_batch.insert(open_batch.size(), fresh);
        end else begin
            batch_lost = 1'b1;
        end
        if (closing) begin
            for (int i = 1; i < open_batch.size(); i++) begin
                moving = open_batch[i];
                j = i;
                while (j > 0 && open_batch[j-1].key > moving.key) begin
                    open_batch[j] = open_batch[j-1];
                    j--;
                end
                open_batch[j] = moving;
            end
            foreach (open_batch[i]) begin
                beat.key     = open_batch[i].key;
                beat.payload = open_batch[i].payload;
                beat.last    = (i == open_batch.size() - 1);
                beat.lost    = batch_lost;
                pending_sorted.insert(pending_sorted.size(), beat);
            end
            open_batch.delete();
            batch_lost = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 8) return $urandom_range(1, 3);
        if (r < 9) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offers one pair after an idle gap and waits for the beat that takes it.
    task automatic offer_pair(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] payload,
                              input bit closing, input int gap, input bit typed,
                              input logic [KEY_W-1:0] exp_key,
                              input logic [VAL_W-1:0] exp_payload);
        t_sorted_beat typed_beat;
        repeat (gap) begin
            @(negedge i_clk);
            i_start     <= 1'b0;
            i_sort_key  <= $urandom;
            i_payload   <= $urandom;
            i_batch_end <= 1'($urandom_range(0, 1));
        end
        @(negedge i_clk);
        i_start     <= 1'b1;
        i_sort_key  <= key;
        i_payload   <= payload;
        i_batch_end <= closing;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        if (typed) begin
            typed_beat.key     = exp_key;
            typed_beat.payload = exp_payload;
            typed_beat.last    = 1'b1;
            typed_beat.lost    = 1'b0;
            pending_sorted.insert(pending_sorted.size(), typed_beat);
        end else begin
            store_pair(key, payload, closing);
        end
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int spread);
        case (spread)
            0: return $urandom_range(0, 7);
            1: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return {1'b1, {(KEY_W-1){1'b0}}};
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int batch_no;
        int blen;
        int spread;
        bit burst;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_sort_key  = '0;
        i_payload   = '0;
        i_batch_end = 1'b0;
        batch_lost  = 1'b0;
        mismatches  = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            offer_pair(directed_rows[r].key, directed_rows[r].payload, directed_rows[r].closing,
                       (r % 3 == 0) ? 0 : pick_gap(), directed_rows[r].typed,
                       directed_rows[r].exp_key, directed_rows[r].exp_payload);
        end
        hold_until_drained();

        sent     = 0;
        batch_no = 0;
        while (sent < RANDOM_PAIRS) begin
            if (batch_no == 0) begin
                blen = DEPTH + 1;
            end else if (batch_no == 1) begin
                blen = DEPTH;
            end else begin
                case ($urandom_range(0, 19))
                    0: blen = $urandom_range(DEPTH + 1, DEPTH + 4);
                    1: blen = DEPTH;
                    2, 3, 4, 5: blen = $urandom_range(9, DEPTH - 1);
                    default: blen = $urandom_range(1, 8);
                endcase
            end
            burst  = ($urandom_range(0, 3) == 0);
            spread = $urandom_range(0, 3);
            for (int i = 0; i < blen; i++) begin
                offer_pair(pick_key(spread), $urandom, (i == blen - 1), burst ? 0 : pick_gap(),
                           1'b0, '0, '0);
            end
            sent += blen;
            if ($urandom_range(0, 7) == 0) begin
                hold_until_drained();
            end
            batch_no++;
        end

        hold_until_drained();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_sorted_beat want;
        if (i_rst_n && o_result_valid !== 1'b0) begin
            if (pending_sorted.size() == 0) begin
                $display("%0t: unexpected sorted beat key %h payload %h", $time,
                         o_sorted_key, o_sorted_payload);
                mismatches++;
            end else begin
                want = pending_sorted.pop_front();
                if (o_sorted_key !== want.key) begin
                    $display("%0t: sorted key expected %h, got %h", $time, want.key,
                             o_sorted_key);
                    mismatches++;
                end
                if (o_sorted_payload !== want.payload) begin
                    $display("%0t: sorted payload expected %h, got %h", $time, want.payload,
                             o_sorted_payload);
                    mismatches++;
                end
                if (o_final_result !== want.last) begin
                    $display("%0t: final flag expected %b, got %b", $time, want.last,
                             o_final_result);
                    mismatches++;
                end
                if (o_overflow !== want.lost) begin
                    $display("%0t: overflow flag expected %b, got %b", $time, want.lost,
                             o_overflow);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if neither a pair nor a sorted beat is taken for too long.
    always @(posedge i_clk) begin
        if ((i_start === 1'b1 && o_busy === 1'b0) || o_result_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule

>>> sort_key_value_pairs.f
rtl/core/skv_pkg.sv
rtl/core/skv_cell.sv
rtl/core/sort_key_value_pairs.sv
verif/tb.sv
